>>> hdl/fpp_pkg.sv
package fpp_pkg;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_W     = 8'h77;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_UK    = 8'h4b;
    localparam logic [7:0] CH_UQ    = 8'h51;
    localparam logic [7:0] CH_LK    = 8'h6b;
    localparam logic [7:0] CH_LQ    = 8'h71;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;

    localparam logic [2:0] TOK_PLACE  = 3'd1;
    localparam logic [2:0] TOK_SIDE   = 3'd2;
    localparam logic [2:0] TOK_CASTLE = 3'd3;
    localparam logic [2:0] TOK_CLOCK  = 3'd5;
    localparam logic [2:0] TOK_MOVE   = 3'd6;
    localparam logic [2:0] TOK_MAX    = 3'd7;

    localparam logic [3:0] BOARD_EDGE = 4'd8;

    typedef struct packed {
        logic accept;
        logic step;
    } fpp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic digit_run;
        logic run_done;
    } fpp_stat_t;

endpackage

>>> hdl/fpp_ctrl.sv
module fpp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  fpp_pkg::fpp_stat_t stat,
    output fpp_pkg::fpp_cmd_t  cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_RUN  = 1'b1;

    logic state_reg;
    logic state_next;

    assign in_ready   = (state_reg == S_IDLE) && stat.out_free;
    assign cmd.accept = in_valid && in_ready;
    assign cmd.step   = (state_reg == S_RUN) && stat.out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.accept && stat.digit_run)
                    state_next = S_RUN;
            end
            S_RUN:
            begin
                if (cmd.step && stat.run_done)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    a_run_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept && stat.digit_run |=> !in_ready)
        else $error("input taken during blank-square run");

    a_no_step_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.accept && cmd.step))
        else $error("accept and step in the same cycle");

    a_run_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RUN) |-> !in_ready)
        else $error("input ready while a blank-square run is active");

endmodule

>>> hdl/fpp_datapath.sv
module fpp_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  logic [7:0]         symbol,
    input  logic               end_of_text,
    input  fpp_pkg::fpp_cmd_t  cmd,
    output fpp_pkg::fpp_stat_t stat,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               kind,
    output logic [5:0]         square,
    output logic [7:0]         piece,
    output logic               black_to_move,
    output logic [3:0]         castle_rights,
    output logic signed [15:0] halfmove_clock,
    output logic signed [15:0] move_number,
    output logic               overflow,
    output logic               last
);

    logic [2:0]  tok_reg, tok_next;
    logic        inside_reg, inside_next;
    logic        chars_reg, chars_next;
    logic [3:0]  rank_reg, rank_next;
    logic [3:0]  file_reg, file_next;
    logic        side_reg, side_next;
    logic [3:0]  rights_reg, rights_next;
    logic [15:0] clock_reg, clock_next;
    logic [15:0] move_reg, move_next;
    logic [15:0] accum_reg, accum_next;
    logic        neg_reg, neg_next;
    logic        stop_reg, stop_next;
    logic        ovf_reg, ovf_next;
    logic [3:0]  count_reg, count_next;
    logic        valid_reg, valid_next;

    logic        o_kind_reg, o_kind_next;
    logic [5:0]  o_square_reg, o_square_next;
    logic [7:0]  o_piece_reg, o_piece_next;
    logic        o_side_reg, o_side_next;
    logic [3:0]  o_rights_reg, o_rights_next;
    logic [15:0] o_hm_reg, o_hm_next;
    logic [15:0] o_mv_reg, o_mv_next;
    logic        o_ovf_reg, o_ovf_next;
    logic        o_last_reg, o_last_next;

    logic [2:0]  tok_eff;
    logic        is_digit19;
    logic        is_digit09;
    logic        out_free;
    logic        off_board;
    logic [19:0] prod;
    logic [15:0] accum_sat;

    assign out_free   = !valid_reg || out_ready;
    assign tok_eff    = (!inside_reg && tok_reg != fpp_pkg::TOK_MAX) ? tok_reg + 3'd1 : tok_reg;
    assign is_digit19 = symbol >= fpp_pkg::CH_ONE && symbol <= fpp_pkg::CH_NINE;
    assign is_digit09 = symbol >= fpp_pkg::CH_ZERO && symbol <= fpp_pkg::CH_NINE;
    assign off_board  = rank_reg >= fpp_pkg::BOARD_EDGE || file_reg >= fpp_pkg::BOARD_EDGE;

    // accum stays at or below 32768, so times ten plus a digit fits 20 bits
    assign prod      = {1'b0, accum_reg, 3'b000} + {3'b000, accum_reg, 1'b0}
                     + {16'd0, 4'(symbol - fpp_pkg::CH_ZERO)};
    assign accum_sat = (prod > 20'd32768) ? 16'h8000 : prod[15:0];

    assign stat.out_free  = out_free;
    assign stat.digit_run = !end_of_text && is_digit19 && tok_eff == fpp_pkg::TOK_PLACE;
    assign stat.run_done  = off_board || count_reg == 4'd1 || file_reg == 4'd7;

    always_comb
    begin
        logic        chars_e;
        logic [3:0]  rank_e;
        logic [3:0]  file_e;
        logic [15:0] accum_e;
        logic        neg_e;
        logic        stop_e;
        logic        store;
        logic [15:0] sval;

        tok_next      = tok_reg;
        inside_next   = inside_reg;
        chars_next    = chars_reg;
        rank_next     = rank_reg;
        file_next     = file_reg;
        side_next     = side_reg;
        rights_next   = rights_reg;
        clock_next    = clock_reg;
        move_next     = move_reg;
        accum_next    = accum_reg;
        neg_next      = neg_reg;
        stop_next     = stop_reg;
        ovf_next      = ovf_reg;
        count_next    = count_reg;
        valid_next    = valid_reg && !out_ready;
        o_kind_next   = o_kind_reg;
        o_square_next = o_square_reg;
        o_piece_next  = o_piece_reg;
        o_side_next   = o_side_reg;
        o_rights_next = o_rights_reg;
        o_hm_next     = o_hm_reg;
        o_mv_next     = o_mv_reg;
        o_ovf_next    = o_ovf_reg;
        o_last_next   = o_last_reg;

        chars_e = chars_reg;
        rank_e  = rank_reg;
        file_e  = file_reg;
        accum_e = accum_reg;
        neg_e   = neg_reg;
        stop_e  = stop_reg;
        store   = 1'b0;
        sval    = 16'd0;

        if (cmd.accept)
        begin
            if (end_of_text)
            begin
                valid_next    = 1'b1;
                o_kind_next   = 1'b1;
                o_square_next = 6'd0;
                o_piece_next  = 8'd0;
                o_side_next   = side_reg;
                o_rights_next = rights_reg;
                o_hm_next     = clock_reg;
                o_mv_next     = move_reg;
                o_ovf_next    = ovf_reg;
                o_last_next   = 1'b1;
                tok_next      = 3'd0;
                inside_next   = 1'b0;
                chars_next    = 1'b0;
                rank_next     = 4'd0;
                file_next     = 4'd0;
                accum_next    = 16'd0;
                neg_next      = 1'b0;
                stop_next     = 1'b0;
            end
            else if (symbol == fpp_pkg::CH_SPACE)
            begin
                inside_next = 1'b0;
            end
            else
            begin
                inside_next = 1'b1;
                tok_next    = tok_eff;
                if (!inside_reg)
                begin
                    chars_e = 1'b0;
                    accum_e = 16'd0;
                    neg_e   = 1'b0;
                    stop_e  = 1'b0;
                    store   = 1'b1;
                    if (tok_eff == fpp_pkg::TOK_PLACE)
                    begin
                        rank_e = 4'd0;
                        file_e = 4'd0;
                    end
                end

                case (tok_eff)
                    fpp_pkg::TOK_PLACE:
                    begin
                        if (symbol == fpp_pkg::CH_SLASH)
                        begin
                            if (rank_e < fpp_pkg::BOARD_EDGE)
                                rank_e = rank_e + 4'd1;
                            file_e = 4'd0;
                        end
                        else if (is_digit19)
                        begin
                            count_next = 4'(symbol - fpp_pkg::CH_ZERO);
                        end
                        else
                        begin
                            if (rank_e < fpp_pkg::BOARD_EDGE && file_e < fpp_pkg::BOARD_EDGE)
                            begin
                                valid_next    = 1'b1;
                                o_kind_next   = 1'b0;
                                o_square_next = {rank_e[2:0], file_e[2:0]};
                                o_piece_next  = symbol;
                                o_side_next   = 1'b0;
                                o_rights_next = 4'd0;
                                o_hm_next     = 16'd0;
                                o_mv_next     = 16'd0;
                                o_ovf_next    = 1'b0;
                                o_last_next   = 1'b1;
                            end
                            else
                            begin
                                ovf_next = 1'b1;
                            end
                            if (file_e < fpp_pkg::BOARD_EDGE)
                                file_e = file_e + 4'd1;
                        end
                    end
                    fpp_pkg::TOK_SIDE:
                    begin
                        if (!chars_e)
                        begin
                            if (symbol == fpp_pkg::CH_W)
                                side_next = 1'b0;
                            else if (symbol == fpp_pkg::CH_B)
                                side_next = 1'b1;
                        end
                        chars_e = 1'b1;
                    end
                    fpp_pkg::TOK_CASTLE:
                    begin
                        if (symbol == fpp_pkg::CH_UK)
                            rights_next = rights_reg | 4'b0001;
                        else if (symbol == fpp_pkg::CH_UQ)
                            rights_next = rights_reg | 4'b0010;
                        else if (symbol == fpp_pkg::CH_LK)
                            rights_next = rights_reg | 4'b0100;
                        else if (symbol == fpp_pkg::CH_LQ)
                            rights_next = rights_reg | 4'b1000;
                    end
                    fpp_pkg::TOK_CLOCK, fpp_pkg::TOK_MOVE:
                    begin
                        if (!stop_e)
                        begin
                            if (!chars_e && symbol >= fpp_pkg::CH_TAB
                                && symbol <= fpp_pkg::CH_CR)
                            begin
                                chars_e = chars_e;
                            end
                            else if (!chars_e && symbol == fpp_pkg::CH_MINUS)
                            begin
                                chars_e = 1'b1;
                                neg_e   = 1'b1;
                            end
                            else if (!chars_e && symbol == fpp_pkg::CH_PLUS)
                            begin
                                chars_e = 1'b1;
                            end
                            else if (is_digit09)
                            begin
                                chars_e = 1'b1;
                                accum_e = (!inside_reg) ? 16'(symbol - fpp_pkg::CH_ZERO)
                                                        : accum_sat;
                                store   = 1'b1;
                            end
                            else
                            begin
                                chars_e = 1'b1;
                                stop_e  = 1'b1;
                            end
                        end
                    end
                    default:
                    begin
                        chars_e = chars_e;
                    end
                endcase

                if (neg_e)
                    sval = 16'd0 - accum_e;
                else
                    sval = accum_e[15] ? 16'h7fff : accum_e;
                if (store && tok_eff == fpp_pkg::TOK_CLOCK)
                    clock_next = sval;
                else if (store && tok_eff == fpp_pkg::TOK_MOVE)
                    move_next = sval;

                chars_next = chars_e;
                rank_next  = rank_e;
                file_next  = file_e;
                accum_next = accum_e;
                neg_next   = neg_e;
                stop_next  = stop_e;
            end
        end
        else if (cmd.step)
        begin
            if (off_board)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                valid_next    = 1'b1;
                o_kind_next   = 1'b0;
                o_square_next = {rank_reg[2:0], file_reg[2:0]};
                o_piece_next  = fpp_pkg::CH_SPACE;
                o_side_next   = 1'b0;
                o_rights_next = 4'd0;
                o_hm_next     = 16'd0;
                o_mv_next     = 16'd0;
                o_ovf_next    = 1'b0;
                o_last_next   = stat.run_done;
                file_next     = file_reg + 4'd1;
                count_next    = count_reg - 4'd1;
                // a blank run that runs off the right edge flags the overflow
                if (file_reg == 4'd7 && count_reg != 4'd1)
                    ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg    <= 3'd0;
            inside_reg <= 1'b0;
            chars_reg  <= 1'b0;
            rank_reg   <= 4'd0;
            file_reg   <= 4'd0;
            side_reg   <= 1'b0;
            rights_reg <= 4'd0;
            clock_reg  <= 16'd0;
            move_reg   <= 16'd0;
            accum_reg  <= 16'd0;
            neg_reg    <= 1'b0;
            stop_reg   <= 1'b0;
            ovf_reg    <= 1'b0;
            count_reg  <= 4'd0;
            valid_reg  <= 1'b0;
        end
        else
        begin
            tok_reg    <= tok_next;
            inside_reg <= inside_next;
            chars_reg  <= chars_next;
            rank_reg   <= rank_next;
            file_reg   <= file_next;
            side_reg   <= side_next;
            rights_reg <= rights_next;
            clock_reg  <= clock_next;
            move_reg   <= move_next;
            accum_reg  <= accum_next;
            neg_reg    <= neg_next;
            stop_reg   <= stop_next;
            ovf_reg    <= ovf_next;
            count_reg  <= count_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        o_kind_reg   <= o_kind_next;
        o_square_reg <= o_square_next;
        o_piece_reg  <= o_piece_next;
        o_side_reg   <= o_side_next;
        o_rights_reg <= o_rights_next;
        o_hm_reg     <= o_hm_next;
        o_mv_reg     <= o_mv_next;
        o_ovf_reg    <= o_ovf_next;
        o_last_reg   <= o_last_next;
    end

    assign out_valid      = valid_reg;
    assign kind           = o_kind_reg;
    assign square         = o_square_reg;
    assign piece          = o_piece_reg;
    assign black_to_move  = o_side_reg;
    assign castle_rights  = o_rights_reg;
    assign halfmove_clock = o_hm_reg;
    assign move_number    = o_mv_reg;
    assign overflow       = o_ovf_reg;
    assign last           = o_last_reg;

    a_summary_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && o_kind_reg |-> o_last_reg)
        else $error("summary beat without last");

    a_step_has_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.step |-> count_reg != 4'd0)
        else $error("blank-square step with empty count");

    a_position_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        rank_reg <= fpp_pkg::BOARD_EDGE && file_reg <= fpp_pkg::BOARD_EDGE)
        else $error("rank or file beyond board edge");

endmodule

>>> hdl/fen_position_parser.sv
// fen position parser
// input channel: in_valid / in_ready carry one text character (symbol) per
// beat, or an end marker (end_of_text = 1) that closes the text.
// output channel: out_valid / out_ready carry one result per beat, either a
// square write (kind 0) or the end-of-text summary (kind 1); last marks the
// final beat caused by one input beat.
// a piece's square write or the summary is registered and appears on the output
// in the cycle after its input beat is accepted. a blank-square digit n writes
// up to n blank squares after it is accepted; the write loop steps one square a
// cycle through the file counter while the output is free, and input is held
// off until it ends.
// the single output register lets a new beat be accepted in the cycle the
// current result is taken; while the receiver stalls, in_ready stays low.
// reset clears the tokenizer, side to move, castling bits, clock, move number
// and overflow flag; the output channel comes up empty.
module fen_position_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         symbol,
    input  logic               end_of_text,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               kind,
    output logic [5:0]         square,
    output logic [7:0]         piece,
    output logic               black_to_move,
    output logic [3:0]         castle_rights,
    output logic signed [15:0] halfmove_clock,
    output logic signed [15:0] move_number,
    output logic               overflow,
    output logic               last
);

    fpp_pkg::fpp_cmd_t  cmd;
    fpp_pkg::fpp_stat_t stat;

    fpp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fpp_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .symbol         (symbol),
        .end_of_text    (end_of_text),
        .cmd            (cmd),
        .stat           (stat),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .square         (square),
        .piece          (piece),
        .black_to_move  (black_to_move),
        .castle_rights  (castle_rights),
        .halfmove_clock (halfmove_clock),
        .move_number    (move_number),
        .overflow       (overflow),
        .last           (last)
    );

endmodule

>>> tb/sv/fen_position_parser_tb.sv
`timescale 1ns / 100ps

module fen_position_parser_tb;

    typedef struct packed {
        logic               kind;
        logic [5:0]         square;
        logic [7:0]         piece;
        logic               black_to_move;
        logic [3:0]         castle_rights;
        logic signed [15:0] halfmove_clock;
        logic signed [15:0] move_number;
        logic               overflow;
        logic               last;
    } fen_result_t;

    typedef struct packed {
        logic [7:0]  sym;
        logic        eot;
        logic        typed;
        fen_result_t res;
    } stim_row_t;

    localparam int DIR_ROWS     = 24;
    localparam int RANDOM_ITEMS = 306;
    localparam int IDLE_PCT     = 11;
    localparam int REPORT_MAX   = 10;

    localparam fen_result_t NO_RESULT = '0;
    localparam fen_result_t EMPTY_SUMMARY = '{kind: 1'b1, square: 6'd0, piece: 8'd0,
        black_to_move: 1'b0, castle_rights: 4'd0, halfmove_clock: 16'sd0,
        move_number: 16'sd0, overflow: 1'b0, last: 1'b1};
    localparam fen_result_t FINAL_SUMMARY = '{kind: 1'b1, square: 6'd0, piece: 8'd0,
        black_to_move: 1'b1, castle_rights: 4'hf, halfmove_clock: -16'sd7,
        move_number: 16'sd9, overflow: 1'b1, last: 1'b1};

    logic               clk         = 1'b0;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    logic [7:0]         symbol      = 8'h00;
    logic               end_of_text = 1'b0;
    logic               out_valid;
    logic               out_ready   = 1'b0;
    logic               kind;
    logic [5:0]         square;
    logic [7:0]         piece;
    logic               black_to_move;
    logic [3:0]         castle_rights;
    logic signed [15:0] halfmove_clock;
    logic signed [15:0] move_number;
    logic               overflow;
    logic               last;

    fen_position_parser uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .symbol         (symbol),
        .end_of_text    (end_of_text),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .kind           (kind),
        .square         (square),
        .piece          (piece),
        .black_to_move  (black_to_move),
        .castle_rights  (castle_rights),
        .halfmove_clock (halfmove_clock),
        .move_number    (move_number),
        .overflow       (overflow),
        .last           (last)
    );

    // parser model state
    logic [2:0]         m_token       = '0;
    logic               m_in_token    = 1'b0;
    logic               m_token_begun = 1'b0;
    logic [3:0]         m_rank        = '0;
    logic [3:0]         m_file        = '0;
    logic               m_black       = 1'b0;
    logic [3:0]         m_rights      = '0;
    logic signed [15:0] m_clock       = '0;
    logic signed [15:0] m_move        = '0;
    logic [15:0]        m_accum       = '0;
    logic               m_negative    = 1'b0;
    logic               m_stopped     = 1'b0;
    logic               m_overflow    = 1'b0;

    fen_result_t results_due[$];
    logic [7:0]  text_chars[$];
    stim_row_t   dir_table[DIR_ROWS];
    string       pieces = "PNBRQKpnbrqk";

    logic        calm      = 1'b0;
    logic        typed_now = 1'b0;
    fen_result_t typed_res = '0;
    fen_result_t seen;
    fen_result_t want;
    int          keep;
    int          mismatches   = 0;
    int          beats_in     = 0;
    int          results_seen = 0;
    int          random_items = 0;
    int          texts        = 0;
    int          drain;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(negedge clk)
    begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic logic signed [15:0] number_value();
        logic [16:0] mag;
        logic [16:0] diff;
        mag = {1'b0, m_accum};
        if (m_negative)
        begin
            if (mag > 17'd32768)
                mag = 17'd32768;
            diff = 17'h10000 - mag;
            return diff[15:0];
        end
        if (mag > 17'd32767)
            mag = 17'd32767;
        return mag[15:0];
    endfunction

    task automatic latch_number();
        if (m_token == fpp_pkg::TOK_CLOCK)
            m_clock = number_value();
        else if (m_token == fpp_pkg::TOK_MOVE)
            m_move = number_value();
    endtask

    task automatic number_symbol(input logic [7:0] c);
        logic [31:0] acc;
        if (m_stopped)
            return;
        if (!m_token_begun)
        begin
            // leading tab through carriage return is skipped
            if (c >= fpp_pkg::CH_TAB && c <= fpp_pkg::CH_CR)
                return;
            m_token_begun = 1'b1;
            if (c == fpp_pkg::CH_MINUS)
            begin
                m_negative = 1'b1;
                return;
            end
            if (c == fpp_pkg::CH_PLUS)
                return;
        end
        if (c >= fpp_pkg::CH_ZERO && c <= fpp_pkg::CH_NINE)
        begin
            acc = m_accum * 10 + (c - fpp_pkg::CH_ZERO);
            if (acc > 32'd32768)
                acc = 32'd32768;
            m_accum = acc[15:0];
            latch_number();
        end
        else
            m_stopped = 1'b1;
    endtask

    task automatic place_symbol(input logic [7:0] c);
        logic        blank;
        int          count;
        int          made;
        fen_result_t wr;
        if (c == fpp_pkg::CH_SLASH)
        begin
            if (m_rank < fpp_pkg::BOARD_EDGE)
                m_rank++;
            m_file = '0;
            return;
        end
        blank = (c >= fpp_pkg::CH_ONE && c <= fpp_pkg::CH_NINE);
        count = blank ? int'(c - fpp_pkg::CH_ZERO) : 1;
        made = 0;
        for (int i = 0; i < count; i++)
        begin
            if (m_rank < fpp_pkg::BOARD_EDGE && m_file < fpp_pkg::BOARD_EDGE)
            begin
                wr = '0;
                wr.square = {m_rank[2:0], m_file[2:0]};
                wr.piece = blank ? fpp_pkg::CH_SPACE : c;
                results_due.push_back(wr);
                made++;
            end
            else
                m_overflow = 1'b1;
            if (m_file < fpp_pkg::BOARD_EDGE)
                m_file++;
        end
        if (made > 0)
        begin
            wr = results_due.pop_back();
            wr.last = 1'b1;
            results_due.push_back(wr);
        end
    endtask

    task automatic parse_symbol(input logic [7:0] c, input logic eot);
        fen_result_t sum;
        if (eot)
        begin
            sum = '0;
            sum.kind = 1'b1;
            sum.black_to_move = m_black;
            sum.castle_rights = m_rights;
            sum.halfmove_clock = m_clock;
            sum.move_number = m_move;
            sum.overflow = m_overflow;
            sum.last = 1'b1;
            results_due.push_back(sum);
            m_token = '0;
            m_in_token = 1'b0;
            m_token_begun = 1'b0;
            m_rank = '0;
            m_file = '0;
            m_accum = '0;
            m_negative = 1'b0;
            m_stopped = 1'b0;
            return;
        end
        if (c == fpp_pkg::CH_SPACE)
        begin
            m_in_token = 1'b0;
            return;
        end
        if (!m_in_token)
        begin
            m_in_token = 1'b1;
            m_token_begun = 1'b0;
            if (m_token < fpp_pkg::TOK_MAX)
                m_token++;
            if (m_token == fpp_pkg::TOK_PLACE)
            begin
                m_rank = '0;
                m_file = '0;
            end
            m_accum = '0;
            m_negative = 1'b0;
            m_stopped = 1'b0;
            latch_number();
        end
        case (m_token)
            fpp_pkg::TOK_PLACE:
                place_symbol(c);
            fpp_pkg::TOK_SIDE:
            begin
                if (!m_token_begun)
                begin
                    if (c == fpp_pkg::CH_W)
                        m_black = 1'b0;
                    else if (c == fpp_pkg::CH_B)
                        m_black = 1'b1;
                end
                m_token_begun = 1'b1;
            end
            fpp_pkg::TOK_CASTLE:
            begin
                if (c == fpp_pkg::CH_UK)
                    m_rights[0] = 1'b1;
                else if (c == fpp_pkg::CH_UQ)
                    m_rights[1] = 1'b1;
                else if (c == fpp_pkg::CH_LK)
                    m_rights[2] = 1'b1;
                else if (c == fpp_pkg::CH_LQ)
                    m_rights[3] = 1'b1;
            end
            fpp_pkg::TOK_CLOCK, fpp_pkg::TOK_MOVE:
                number_symbol(c);
            default:
            begin
            end
        endcase
    endtask

    function automatic string describe(input fen_result_t r);
        return $sformatf({"kind %0d sq %0d piece %02h side %0d rights %h",
                          " hm %0d mv %0d ovf %0d last %0d"},
            r.kind, r.square, r.piece, r.black_to_move, r.castle_rights,
            $signed(r.halfmove_clock), $signed(r.move_number), r.overflow, r.last);
    endfunction

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                seen = {kind, square, piece, black_to_move, castle_rights,
                        halfmove_clock, move_number, overflow, last};
                results_seen++;
                if (results_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_MAX)
                        $display("unexpected beat at %0t: %s", $realtime, describe(seen));
                end
                else
                begin
                    want = results_due.pop_front();
                    if (seen.kind !== want.kind || seen.square !== want.square ||
                        seen.piece !== want.piece ||
                        seen.black_to_move !== want.black_to_move ||
                        seen.castle_rights !== want.castle_rights ||
                        seen.halfmove_clock !== want.halfmove_clock ||
                        seen.move_number !== want.move_number ||
                        seen.overflow !== want.overflow || seen.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_MAX)
                        begin
                            $display("mismatch at %0t", $realtime);
                            $display("  expected %s", describe(want));
                            $display("  actual   %s", describe(seen));
                        end
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                keep = results_due.size();
                parse_symbol(symbol, end_of_text);
                if (typed_now)
                begin
                    while (results_due.size() > keep)
                        void'(results_due.pop_back());
                    results_due.push_back(typed_res);
                end
                beats_in++;
            end
        end
    end

    task automatic send_beat(input logic [7:0] s, input logic e, input logic typed,
                             input fen_result_t res);
        if (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
            while (!calm && $urandom_range(99) < IDLE_PCT)
                @(negedge clk);
        end
        typed_now = typed;
        typed_res = res;
        symbol <= s;
        end_of_text <= e;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic add_spaces();
        repeat ($urandom_range(1, 3))
            text_chars.push_back(fpp_pkg::CH_SPACE);
    endtask

    task automatic add_number();
        logic [7:0] ch;
        int         roll;
        int         digits;
        if ($urandom_range(99) < 15)
        begin
            repeat ($urandom_range(1, 2))
            begin
                ch = 8'($urandom_range(fpp_pkg::CH_TAB, fpp_pkg::CH_CR));
                text_chars.push_back(ch);
            end
        end
        roll = $urandom_range(99);
        if (roll < 10)
            text_chars.push_back(fpp_pkg::CH_MINUS);
        else if (roll < 20)
            text_chars.push_back(fpp_pkg::CH_PLUS);
        roll = $urandom_range(99);
        digits = (roll < 10) ? 0 : (roll < 80) ? $urandom_range(1, 3) : $urandom_range(5, 6);
        repeat (digits)
        begin
            ch = 8'(fpp_pkg::CH_ZERO + $urandom_range(0, 9));
            text_chars.push_back(ch);
        end
        if ($urandom_range(99) < 10)
        begin
            ch = 8'($urandom_range(33, 126));
            text_chars.push_back(ch);
        end
    endtask

    task automatic compose_text();
        logic [7:0] ch;
        int         ranks;
        int         files;
        int         d;
        int         n;
        text_chars.delete();
        if ($urandom_range(99) < 15)
        begin
            // raw noise
            repeat ($urandom_range(1, 15))
            begin
                ch = ($urandom_range(3) == 0) ? fpp_pkg::CH_SPACE : 8'($urandom_range(255));
                text_chars.push_back(ch);
            end
            return;
        end
        if ($urandom_range(99) < 10)
            add_spaces();
        ranks = ($urandom_range(99) < 10) ? 9 : 8;
        for (int r = 0; r < ranks; r++)
        begin
            if (r > 0)
                text_chars.push_back(fpp_pkg::CH_SLASH);
            files = 0;
            while (files < 8)
            begin
                if ($urandom_range(99) < 35)
                begin
                    d = ($urandom_range(99) < 5) ? $urandom_range(1, 9)
                                                 : $urandom_range(1, 8 - files);
                    ch = 8'(fpp_pkg::CH_ZERO + d);
                    files += d;
                end
                else
                begin
                    ch = ($urandom_range(99) < 5) ? 8'($urandom_range(255))
                                                  : pieces[$urandom_range(0, 11)];
                    files++;
                end
                text_chars.push_back(ch);
            end
            if ($urandom_range(99) < 5)
                text_chars.push_back(pieces[$urandom_range(0, 11)]);
        end
        add_spaces();
        n = $urandom_range(99);
        ch = (n < 45) ? fpp_pkg::CH_W : (n < 90) ? fpp_pkg::CH_B : 8'($urandom_range(33, 126));
        text_chars.push_back(ch);
        if ($urandom_range(99) < 20)
        begin
            ch = ($urandom_range(1)) ? fpp_pkg::CH_W : fpp_pkg::CH_B;
            text_chars.push_back(ch);
        end
        add_spaces();
        n = text_chars.size();
        if ($urandom_range(1))
            text_chars.push_back(fpp_pkg::CH_UK);
        if ($urandom_range(1))
            text_chars.push_back(fpp_pkg::CH_UQ);
        if ($urandom_range(1))
            text_chars.push_back(fpp_pkg::CH_LK);
        if ($urandom_range(1))
            text_chars.push_back(fpp_pkg::CH_LQ);
        if (text_chars.size() == n)
            text_chars.push_back(fpp_pkg::CH_MINUS);
        if ($urandom_range(99) < 10)
        begin
            ch = 8'($urandom_range(33, 126));
            text_chars.push_back(ch);
        end
        add_spaces();
        if ($urandom_range(1))
            text_chars.push_back(fpp_pkg::CH_MINUS);
        else
        begin
            ch = 8'("a" + $urandom_range(0, 7));
            text_chars.push_back(ch);
            ch = ($urandom_range(1)) ? "3" : "6";
            text_chars.push_back(ch);
        end
        add_spaces();
        add_number();
        add_spaces();
        add_number();
        if ($urandom_range(99) < 10)
        begin
            // tokens past the move number
            add_spaces();
            repeat ($urandom_range(1, 3))
            begin
                ch = 8'($urandom_range(33, 126));
                text_chars.push_back(ch);
            end
        end
        if ($urandom_range(99) < 25)
        begin
            n = $urandom_range(1, text_chars.size());
            while (text_chars.size() > n)
                void'(text_chars.pop_back());
        end
    endtask

    initial
    begin
        dir_table[0]  = {8'h00,                   1'b1, 1'b1, EMPTY_SUMMARY};
        dir_table[1]  = {fpp_pkg::CH_NINE,        1'b0, 1'b0, NO_RESULT};
        dir_table[2]  = {fpp_pkg::CH_SLASH,       1'b0, 1'b0, NO_RESULT};
        dir_table[3]  = {fpp_pkg::CH_UK,          1'b0, 1'b0, NO_RESULT};
        dir_table[4]  = {8'h00,                   1'b0, 1'b0, NO_RESULT};
        dir_table[5]  = {8'hff,                   1'b0, 1'b0, NO_RESULT};
        dir_table[6]  = {fpp_pkg::CH_ONE,         1'b0, 1'b0, NO_RESULT};
        dir_table[7]  = {fpp_pkg::CH_SPACE,       1'b0, 1'b0, NO_RESULT};
        dir_table[8]  = {fpp_pkg::CH_SPACE,       1'b0, 1'b0, NO_RESULT};
        dir_table[9]  = {fpp_pkg::CH_B,           1'b0, 1'b0, NO_RESULT};
        dir_table[10] = {fpp_pkg::CH_W,           1'b0, 1'b0, NO_RESULT};
        dir_table[11] = {fpp_pkg::CH_SPACE,       1'b0, 1'b0, NO_RESULT};
        dir_table[12] = {fpp_pkg::CH_UK,          1'b0, 1'b0, NO_RESULT};
        dir_table[13] = {fpp_pkg::CH_UQ,          1'b0, 1'b0, NO_RESULT};
        dir_table[14] = {fpp_pkg::CH_LK,          1'b0, 1'b0, NO_RESULT};
        dir_table[15] = {fpp_pkg::CH_LQ,          1'b0, 1'b0, NO_RESULT};
        dir_table[16] = {fpp_pkg::CH_SPACE,       1'b0, 1'b0, NO_RESULT};
        dir_table[17] = {fpp_pkg::CH_MINUS,       1'b0, 1'b0, NO_RESULT};
        dir_table[18] = {fpp_pkg::CH_SPACE,       1'b0, 1'b0, NO_RESULT};
        dir_table[19] = {fpp_pkg::CH_MINUS,       1'b0, 1'b0, NO_RESULT};
        dir_table[20] = {fpp_pkg::CH_ZERO + 8'd7, 1'b0, 1'b0, NO_RESULT};
        dir_table[21] = {fpp_pkg::CH_SPACE,       1'b0, 1'b0, NO_RESULT};
        dir_table[22] = {fpp_pkg::CH_NINE,        1'b0, 1'b0, NO_RESULT};
        dir_table[23] = {8'hff,                   1'b1, 1'b1, FINAL_SUMMARY};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_beat(dir_table[i].sym, dir_table[i].eot, dir_table[i].typed,
                      dir_table[i].res);

        while (random_items < RANDOM_ITEMS)
        begin
            // quiet stretch with no idling on either side
            calm = (random_items >= 120 && random_items < 200);
            compose_text();
            foreach (text_chars[i])
            begin
                // leave room for the end marker
                if (random_items >= RANDOM_ITEMS - 1)
                    break;
                send_beat(text_chars[i], 1'b0, 1'b0, NO_RESULT);
                random_items++;
            end
            send_beat(8'($urandom_range(255)), 1'b1, 1'b0, NO_RESULT);
            random_items++;
            texts++;
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        drain = 0;
        while (results_due.size() != 0 && drain < 5000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (20) @(posedge clk);

        if (results_due.size() != 0)
        begin
            $display("%0d expected beats never arrived", results_due.size());
            mismatches += results_due.size();
        end

        $display("covered %0d input beats, %0d random texts, %0d result beats compared",
                 beats_in, texts, results_seen);
        $display("placement with overflow, side, castling and saturated clock tokens seen");
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

>>> sim.f
hdl/fpp_pkg.sv
hdl/fpp_ctrl.sv
hdl/fpp_datapath.sv
hdl/fen_position_parser.sv
tb/sv/fen_position_parser_tb.sv
